@@ rtl/aes192_pkg.sv @@
// Package: AES-192 decrypt types, S-box tables and GF(2^8) helpers.
package aes192_pkg;

  localparam int unsigned NUM_ROUNDS = 12;
  localparam int unsigned KEY_WORDS  = 6;

  typedef logic [127:0] block_t;
  typedef logic [31:0]  word_t;

  typedef enum logic [1:0] {
    REG_KEY0 = 2'd0,
    REG_KEY1 = 2'd1,
    REG_KEY2 = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    KS_IDLE   = 2'd0,
    KS_EXPAND = 2'd1,
    KS_DONE   = 2'd2
  } ks_state_t;

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52, 8'h09, 8'h6A, 8'hD5, 8'h30, 8'h36, 8'hA5, 8'h38,
    8'hBF, 8'h40, 8'hA3, 8'h9E, 8'h81, 8'hF3, 8'hD7, 8'hFB,
    8'h7C, 8'hE3, 8'h39, 8'h82, 8'h9B, 8'h2F, 8'hFF, 8'h87,
    8'h34, 8'h8E, 8'h43, 8'h44, 8'hC4, 8'hDE, 8'hE9, 8'hCB,
    8'h54, 8'h7B, 8'h94, 8'h32, 8'hA6, 8'hC2, 8'h23, 8'h3D,
    8'hEE, 8'h4C, 8'h95, 8'h0B, 8'h42, 8'hFA, 8'hC3, 8'h4E,
    8'h08, 8'h2E, 8'hA1, 8'h66, 8'h28, 8'hD9, 8'h24, 8'hB2,
    8'h76, 8'h5B, 8'hA2, 8'h49, 8'h6D, 8'h8B, 8'hD1, 8'h25,
    8'h72, 8'hF8, 8'hF6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
    8'hD4, 8'hA4, 8'h5C, 8'hCC, 8'h5D, 8'h65, 8'hB6, 8'h92,
    8'h6C, 8'h70, 8'h48, 8'h50, 8'hFD, 8'hED, 8'hB9, 8'hDA,
    8'h5E, 8'h15, 8'h46, 8'h57, 8'hA7, 8'h8D, 8'h9D, 8'h84,
    8'h90, 8'hD8, 8'hAB, 8'h00, 8'h8C, 8'hBC, 8'hD3, 8'h0A,
    8'hF7, 8'hE4, 8'h58, 8'h05, 8'hB8, 8'hB3, 8'h45, 8'h06,
    8'hD0, 8'h2C, 8'h1E, 8'h8F, 8'hCA, 8'h3F, 8'h0F, 8'h02,
    8'hC1, 8'hAF, 8'hBD, 8'h03, 8'h01, 8'h13, 8'h8A, 8'h6B,
    8'h3A, 8'h91, 8'h11, 8'h41, 8'h4F, 8'h67, 8'hDC, 8'hEA,
    8'h97, 8'hF2, 8'hCF, 8'hCE, 8'hF0, 8'hB4, 8'hE6, 8'h73,
    8'h96, 8'hAC, 8'h74, 8'h22, 8'hE7, 8'hAD, 8'h35, 8'h85,
    8'hE2, 8'hF9, 8'h37, 8'hE8, 8'h1C, 8'h75, 8'hDF, 8'h6E,
    8'h47, 8'hF1, 8'h1A, 8'h71, 8'h1D, 8'h29, 8'hC5, 8'h89,
    8'h6F, 8'hB7, 8'h62, 8'h0E, 8'hAA, 8'h18, 8'hBE, 8'h1B,
    8'hFC, 8'h56, 8'h3E, 8'h4B, 8'hC6, 8'hD2, 8'h79, 8'h20,
    8'h9A, 8'hDB, 8'hC0, 8'hFE, 8'h78, 8'hCD, 8'h5A, 8'hF4,
    8'h1F, 8'hDD, 8'hA8, 8'h33, 8'h88, 8'h07, 8'hC7, 8'h31,
    8'hB1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hEC, 8'h5F,
    8'h60, 8'h51, 8'h7F, 8'hA9, 8'h19, 8'hB5, 8'h4A, 8'h0D,
    8'h2D, 8'hE5, 8'h7A, 8'h9F, 8'h93, 8'hC9, 8'h9C, 8'hEF,
    8'hA0, 8'hE0, 8'h3B, 8'h4D, 8'hAE, 8'h2A, 8'hF5, 8'hB0,
    8'hC8, 8'hEB, 8'hBB, 8'h3C, 8'h83, 8'h53, 8'h99, 8'h61,
    8'h17, 8'h2B, 8'h04, 8'h7E, 8'hBA, 8'h77, 8'hD6, 8'h26,
    8'hE1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0C, 8'h7D
  };

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63, 8'h7C, 8'h77, 8'h7B, 8'hF2, 8'h6B, 8'h6F, 8'hC5,
    8'h30, 8'h01, 8'h67, 8'h2B, 8'hFE, 8'hD7, 8'hAB, 8'h76,
    8'hCA, 8'h82, 8'hC9, 8'h7D, 8'hFA, 8'h59, 8'h47, 8'hF0,
    8'hAD, 8'hD4, 8'hA2, 8'hAF, 8'h9C, 8'hA4, 8'h72, 8'hC0,
    8'hB7, 8'hFD, 8'h93, 8'h26, 8'h36, 8'h3F, 8'hF7, 8'hCC,
    8'h34, 8'hA5, 8'hE5, 8'hF1, 8'h71, 8'hD8, 8'h31, 8'h15,
    8'h04, 8'hC7, 8'h23, 8'hC3, 8'h18, 8'h96, 8'h05, 8'h9A,
    8'h07, 8'h12, 8'h80, 8'hE2, 8'hEB, 8'h27, 8'hB2, 8'h75,
    8'h09, 8'h83, 8'h2C, 8'h1A, 8'h1B, 8'h6E, 8'h5A, 8'hA0,
    8'h52, 8'h3B, 8'hD6, 8'hB3, 8'h29, 8'hE3, 8'h2F, 8'h84,
    8'h53, 8'hD1, 8'h00, 8'hED, 8'h20, 8'hFC, 8'hB1, 8'h5B,
    8'h6A, 8'hCB, 8'hBE, 8'h39, 8'h4A, 8'h4C, 8'h58, 8'hCF,
    8'hD0, 8'hEF, 8'hAA, 8'hFB, 8'h43, 8'h4D, 8'h33, 8'h85,
    8'h45, 8'hF9, 8'h02, 8'h7F, 8'h50, 8'h3C, 8'h9F, 8'hA8,
    8'h51, 8'hA3, 8'h40, 8'h8F, 8'h92, 8'h9D, 8'h38, 8'hF5,
    8'hBC, 8'hB6, 8'hDA, 8'h21, 8'h10, 8'hFF, 8'hF3, 8'hD2,
    8'hCD, 8'h0C, 8'h13, 8'hEC, 8'h5F, 8'h97, 8'h44, 8'h17,
    8'hC4, 8'hA7, 8'h7E, 8'h3D, 8'h64, 8'h5D, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4F, 8'hDC, 8'h22, 8'h2A, 8'h90, 8'h88,
    8'h46, 8'hEE, 8'hB8, 8'h14, 8'hDE, 8'h5E, 8'h0B, 8'hDB,
    8'hE0, 8'h32, 8'h3A, 8'h0A, 8'h49, 8'h06, 8'h24, 8'h5C,
    8'hC2, 8'hD3, 8'hAC, 8'h62, 8'h91, 8'h95, 8'hE4, 8'h79,
    8'hE7, 8'hC8, 8'h37, 8'h6D, 8'h8D, 8'hD5, 8'h4E, 8'hA9,
    8'h6C, 8'h56, 8'hF4, 8'hEA, 8'h65, 8'h7A, 8'hAE, 8'h08,
    8'hBA, 8'h78, 8'h25, 8'h2E, 8'h1C, 8'hA6, 8'hB4, 8'hC6,
    8'hE8, 8'hDD, 8'h74, 8'h1F, 8'h4B, 8'hBD, 8'h8B, 8'h8A,
    8'h70, 8'h3E, 8'hB5, 8'h66, 8'h48, 8'h03, 8'hF6, 8'h0E,
    8'h61, 8'h35, 8'h57, 8'hB9, 8'h86, 8'hC1, 8'h1D, 8'h9E,
    8'hE1, 8'hF8, 8'h98, 8'h11, 8'h69, 8'hD9, 8'h8E, 8'h94,
    8'h9B, 8'h1E, 8'h87, 8'hE9, 8'hCE, 8'h55, 8'h28, 8'hDF,
    8'h8C, 8'hA1, 8'h89, 8'h0D, 8'hBF, 8'hE6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2D, 8'h0F, 8'hB0, 8'h54, 8'hBB, 8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
  endfunction

  function automatic logic [7:0] mul9(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul9 = a8 ^ a;
  endfunction

  function automatic logic [7:0] mul11(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul11 = a8 ^ a2 ^ a;
  endfunction

  function automatic logic [7:0] mul13(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul13 = a8 ^ a4 ^ a;
  endfunction

  function automatic logic [7:0] mul14(input logic [7:0] a);
    logic [7:0] a2, a4, a8;
    a2 = xtime(a); a4 = xtime(a2); a8 = xtime(a4);
    mul14 = a8 ^ a4 ^ a2;
  endfunction

  // InvShiftRows then InvSubBytes; byte 0 in bits 127:120
  function automatic block_t inv_shift_sub(input block_t s);
    block_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8*(4*((c + r) % 4) + r) -: 8] = INV_SBOX[s[127 - 8*(4*c + r) -: 8]];
      end
    end
    inv_shift_sub = t;
  endfunction

  function automatic block_t inv_mix(input block_t s);
    block_t t;
    logic [7:0] a0, a1, a2, a3;
    for (int c = 0; c < 4; c++) begin
      a0 = s[127 - 32*c -: 8];
      a1 = s[119 - 32*c -: 8];
      a2 = s[111 - 32*c -: 8];
      a3 = s[103 - 32*c -: 8];
      t[127 - 32*c -: 8] = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
      t[119 - 32*c -: 8] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
      t[111 - 32*c -: 8] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
      t[103 - 32*c -: 8] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
    end
    inv_mix = t;
  endfunction

endpackage

@@ rtl/aes192_block_decrypt_core.sv @@
// Top level: AES-192 ECB decryption, 13-stage round pipeline with key schedule.
//
// Usage:
//   Configuration: write the cipher key through cfg_we/cfg_idx/cfg_data, index 0..2
//   (64 bits each, key byte 0 in bits 63:56). A write to an unknown index is ignored.
//   After any key write (and after reset) the round keys are expanded on the next
//   start: busy rises while the schedule produces one word per cycle, then the
//   waiting block enters the pipeline.
//   Data: a beat is taken at a clock edge with start high and busy low. Blocks may
//   follow one per cycle; throughput is one block per clock once keys are expanded.
//   Pipeline: the result passes one registered stage for the initial AddRoundKey and
//   one per inverse round before it reaches the ports.
//   Result: plaintext_high/low valid for exactly one cycle with done high. The
//   receiver cannot stall, so the pipeline never holds.
//   Reset: rst synchronous, active high; clears key registers to zero, pipeline
//   valid bits, and the expanded flag. Round-key words need no clearing.
module aes192_block_decrypt_core
  import aes192_pkg::*;
#(
  parameter int unsigned ROUND_KEY_WORDS = 52
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] ciphertext_high,
  input  logic [63:0] ciphertext_low,
  output logic        done,
  output logic [63:0] plaintext_high,
  output logic [63:0] plaintext_low
);

  localparam int unsigned NR = ROUND_KEY_WORDS / 4 - 1;

  logic [63:0] key_reg [3];
  logic        expanded;
  logic        ks_go, ks_done, ks_run;
  logic [ROUND_KEY_WORDS*32-1:0] rk_flat;
  logic        pend;
  logic        accept;

  block_t      st    [NR+1];
  logic        vld   [NR+1];
  block_t      held;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_reg[0] <= '0;
      key_reg[1] <= '0;
      key_reg[2] <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_KEY0: key_reg[0] <= cfg_data;
        REG_KEY1: key_reg[1] <= cfg_data;
        REG_KEY2: key_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // start with stale keys: hold the block, expand, then issue it
  assign ks_go  = start && !busy && !expanded;
  assign accept = start && !busy;
  assign busy   = pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      expanded <= 1'b0;
      pend     <= 1'b0;
      ks_run   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_idx inside {REG_KEY0, REG_KEY1, REG_KEY2})) expanded <= 1'b0;
      else if (ks_run && ks_done) expanded <= 1'b1;
      if (ks_go) begin
        pend   <= 1'b1;
        ks_run <= 1'b1;
      end else if (ks_run && ks_done) begin
        pend   <= 1'b0;
        ks_run <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held <= {ciphertext_high, ciphertext_low};
  end

  aes192_keysched #(.RK_WORDS(ROUND_KEY_WORDS)) u_ks (
    .clk     (clk),
    .rst     (rst),
    .key     ({key_reg[0], key_reg[1], key_reg[2]}),
    .go      (ks_go),
    .done    (ks_done),
    .rk_flat (rk_flat)
  );

  function automatic block_t rkey(input logic [ROUND_KEY_WORDS*32-1:0] f, input int r);
    rkey = {f[(4*r)*32 +: 32], f[(4*r+1)*32 +: 32],
            f[(4*r+2)*32 +: 32], f[(4*r+3)*32 +: 32]};
  endfunction

  logic   issue_now, issue_held;
  block_t entry;
  assign issue_now  = accept && expanded;
  assign issue_held = ks_run && ks_done;
  assign entry      = issue_held ? held : {ciphertext_high, ciphertext_low};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= NR; i++) vld[i] <= 1'b0;
    end else begin
      vld[0] <= issue_now || issue_held;
      for (int i = 1; i <= NR; i++) vld[i] <= vld[i-1];
    end
  end

  always_ff @(posedge clk) begin
    st[0] <= entry ^ rkey(rk_flat, NR);
    for (int i = 1; i < NR; i++) begin
      st[i] <= inv_mix(inv_shift_sub(st[i-1]) ^ rkey(rk_flat, NR - i));
    end
    st[NR] <= inv_shift_sub(st[NR-1]) ^ rkey(rk_flat, 0);
  end

  assign done           = vld[NR];
  assign plaintext_high = st[NR][127:64];
  assign plaintext_low  = st[NR][63:0];

`ifndef SYNTH
  a_no_issue_stale: assert property (@(posedge clk) disable iff (rst)
    issue_now |-> !ks_run) else $error("block issued during expansion");
  a_done_latency: assert property (@(posedge clk) disable iff (rst)
    issue_now |-> ##13 done) else $error("result missing");
  a_busy_go: assert property (@(posedge clk) disable iff (rst)
    ks_go |=> busy) else $error("busy not raised for expansion");
  a_held_issue: assert property (@(posedge clk) disable iff (rst)
    issue_held |=> !busy) else $error("busy stuck after expansion");
`endif

endmodule

@@ rtl/aes192_keysched.sv @@
// Key schedule: expands the 192-bit key one word per cycle into round-key registers.
module aes192_keysched
  import aes192_pkg::*;
#(
  parameter int unsigned RK_WORDS = 52
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [191:0]        key,
  input  logic                go,
  output logic                done,
  output logic [RK_WORDS*32-1:0] rk_flat
);

  localparam int unsigned CW = $clog2(RK_WORDS + 1);

  ks_state_t     state, state_next;
  logic [CW-1:0] cnt;
  logic [3:0]    rc_idx;
  word_t         rk [RK_WORDS];
  word_t         w_new, t_rot, t_sub;
  logic [2:0]    phase;
  logic [7:0]    rcon;

  // last six words form a sliding window; rk[cnt-6] and rk[cnt-1] read through it
  word_t win [KEY_WORDS];

  always_comb begin
    case (rc_idx)
      4'd1: rcon = 8'h01;
      4'd2: rcon = 8'h02;
      4'd3: rcon = 8'h04;
      4'd4: rcon = 8'h08;
      4'd5: rcon = 8'h10;
      4'd6: rcon = 8'h20;
      4'd7: rcon = 8'h40;
      4'd8: rcon = 8'h80;
      4'd9: rcon = 8'h1B;
      4'd10: rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
  end

  always_comb begin
    t_rot = {win[5][23:0], win[5][31:24]};
    t_sub = {FWD_SBOX[t_rot[31:24]], FWD_SBOX[t_rot[23:16]],
             FWD_SBOX[t_rot[15:8]], FWD_SBOX[t_rot[7:0]]};
    if (phase == 3'd0) w_new = win[0] ^ t_sub ^ {rcon, 24'h0};
    else               w_new = win[0] ^ win[5];
  end

  always_comb begin
    state_next = state;
    case (state)
      KS_IDLE:   if (go) state_next = KS_EXPAND;
      KS_EXPAND: if (cnt == CW'(RK_WORDS - 1)) state_next = KS_DONE;
      KS_DONE:   if (go) state_next = KS_EXPAND;
      default:   state_next = KS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= KS_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (go) begin
      for (int i = 0; i < KEY_WORDS; i++) begin
        win[i] <= key[191 - 32*i -: 32];
        rk[i]  <= key[191 - 32*i -: 32];
      end
      cnt    <= CW'(KEY_WORDS);
      phase  <= 3'd0;
      rc_idx <= 4'd1;
    end else if (state == KS_EXPAND) begin
      rk[cnt[$clog2(RK_WORDS)-1:0]] <= w_new;
      for (int i = 0; i < KEY_WORDS - 1; i++) win[i] <= win[i+1];
      win[5] <= w_new;
      cnt    <= cnt + 1'b1;
      if (phase == 3'd5) begin
        phase  <= 3'd0;
        rc_idx <= (rc_idx == 4'd10) ? 4'd0 : rc_idx + 1'b1;
      end else begin
        phase <= phase + 1'b1;
      end
    end
  end

  assign done = (state == KS_DONE) && !go;

  always_comb begin
    for (int i = 0; i < RK_WORDS; i++) rk_flat[i*32 +: 32] = rk[i];
  end

`ifndef SYNTH
  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    go |=> state == KS_EXPAND) else $error("expansion did not start");
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    state == KS_EXPAND |-> cnt < CW'(RK_WORDS)) else $error("word counter overran");
  a_done_after: assert property (@(posedge clk) disable iff (rst)
    $rose(state == KS_DONE) |-> $past(cnt) == CW'(RK_WORDS - 1))
    else $error("expansion ended early");
`endif

endmodule
